FILE: hdl/bdac_pkg.sv
// Shared types, constants and the double-dabble step for the decimal ASCII converter.
package bdac_pkg;

  localparam int VALUE_W        = 32;
  localparam int DIGITS         = 10;
  localparam int DIGIT_W        = 4;
  localparam int BCD_W          = DIGITS * DIGIT_W;
  localparam int NUM_STAGES     = 4;
  localparam int BITS_PER_STAGE = VALUE_W / NUM_STAGES;
  localparam int CHAR_W         = 6;
  localparam int COUNT_W        = 4;
  localparam int IDX_W          = 4;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  typedef logic [DIGITS-1:0][DIGIT_W-1:0] bcd_t;
  typedef logic [IDX_W-1:0]               idx_t;
  typedef logic [COUNT_W-1:0]             count_t;

  // Partial conversion: decimal digits so far and binary bits still to shift in.
  typedef struct packed {
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
  } dd_t;

  // One group of shift-add-3 steps, BITS_PER_STAGE bits long.
  function automatic dd_t dabble(input dd_t d_in);
    dd_t                d;
    logic [BCD_W-1:0]   flat;
    d = d_in;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int k = 0; k < DIGITS; k++) begin
        if (d.bcd[k] >= ADJ_LIMIT) begin
          d.bcd[k] = d.bcd[k] + ADJ_ADD;
        end
      end
      flat  = d.bcd;
      flat  = {flat[BCD_W-2:0], d.bin[VALUE_W-1]};
      d.bcd = flat;
      d.bin = {d.bin[VALUE_W-2:0], 1'b0};
    end
    return d;
  endfunction

endpackage

FILE: hdl/bdac_dd_stage.sv
// One registered double-dabble pipeline stage with valid and backpressure.
module bdac_dd_stage import bdac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  dd_t  up_data,
  output logic up_ready,
  output logic dn_valid,
  output dd_t  dn_data,
  input  logic dn_ready
);

  logic valid_r, valid_nxt;
  dd_t  data_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= dabble(up_data);
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hdl/bdac_serializer.sv
// Digit serializer: finds the digit count and sends one ASCII digit per beat.
module bdac_serializer import bdac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  bcd_t              up_bcd,
  output logic              up_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_digit_char,
  output count_t            out_digit_count,
  output logic              out_last_digit
);

  logic   busy_r, busy_nxt;
  bcd_t   bcd_r;
  count_t cnt_r;
  idx_t   idx_r, idx_nxt;
  count_t load_cnt;
  logic   take;

  // Highest nonzero digit sets the count; zero still gives one digit.
  always_comb begin
    load_cnt = count_t'(1);
    for (int k = 1; k < DIGITS; k++) begin
      if (up_bcd[k] != '0) begin
        load_cnt = count_t'(k + 1);
      end
    end
  end

  assign out_valid       = busy_r;
  assign out_last_digit  = (idx_r == '0);
  assign out_digit_count = cnt_r;
  assign out_digit_char  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_r[idx_r]};

  assign take     = busy_r && !out_stall;
  assign up_ready = !busy_r || (take && out_last_digit);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (up_ready) begin
      busy_nxt = up_valid;
      idx_nxt  = idx_t'(load_cnt - count_t'(1));
    end else if (take) begin
      idx_nxt = idx_r - idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (up_ready && up_valid) begin
      bcd_r <= up_bcd;
      cnt_r <= load_cnt;
    end
  end

endmodule

FILE: hdl/binary_to_decimal_ascii_top.sv
// Top level of the 32-bit binary to decimal ASCII converter.
//
//  channel | ports                                            | dir | beat
//  input   | in_valid, in_stall, in_value[31:0]               | in  | one value
//  result  | out_valid, out_stall, out_digit_char[5:0],       | out | one digit
//          | out_digit_count[3:0], out_last_digit             |     |
//
// A value passes four double-dabble stages of eight bits each, then the serializer.
// The first digit shows once the value has passed the stage registers and the
// serializer register. The serializer sends digit_count digits (1 to 10) per item,
// one per cycle while out_stall is low, and loads the next item with its last one.
// Reset clears only the valid and busy bits.
// A stall on the result side holds the serializer, then fills the stages, then
// raises in_stall; no beat is lost or repeated.
module binary_to_decimal_ascii_top import bdac_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_digit_char,
  output count_t             out_digit_count,
  output logic               out_last_digit
);

  logic [NUM_STAGES:0] v;
  logic [NUM_STAGES:0] rdy;
  dd_t                 d [NUM_STAGES+1];

  assign v[0]     = in_valid;
  assign d[0]     = '{bcd: '0, bin: in_value};
  assign in_stall = !rdy[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    bdac_dd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[g]),
      .up_data  (d[g]),
      .up_ready (rdy[g]),
      .dn_valid (v[g+1]),
      .dn_data  (d[g+1]),
      .dn_ready (rdy[g+1])
    );
  end

  bdac_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (v[NUM_STAGES]),
    .up_bcd          (d[NUM_STAGES].bcd),
    .up_ready        (rdy[NUM_STAGES]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_char  (out_digit_char),
    .out_digit_count (out_digit_count),
    .out_last_digit  (out_last_digit)
  );

endmodule

FILE: hdl/bdac_checker.sv
// Port-level checker for the converter, bound to the top level.
module bdac_checker import bdac_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_digit_char,
  input count_t            out_digit_count,
  input logic              out_last_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit_char)
      && $stable(out_digit_count) && $stable(out_last_digit))
    else $error("result beat changed while stalled");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_char >= 6'd48 && out_digit_char <= 6'd57)
    else $error("digit character out of range");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_count >= 4'd1 && out_digit_count <= 4'd10)
    else $error("digit count out of range");

  // A run continues with the same count until its last digit.
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_digit |=>
      out_valid && out_digit_count == $past(out_digit_count))
    else $error("run broken or count changed inside a run");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digit_count == 4'd1 |-> out_last_digit)
    else $error("single-digit run without last flag");

endmodule

bind binary_to_decimal_ascii_top bdac_checker u_bdac_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digit_char  (out_digit_char),
  .out_digit_count (out_digit_count),
  .out_last_digit  (out_last_digit)
);

FILE: bench/testbench.sv
// Self-checking bench for the binary to decimal ASCII converter.
`timescale 1ns / 100ps

module testbench;
  import bdac_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int DECIMAL_BASE = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    count_t            count;
    logic              last;
  } digit_beat_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_digit_char;
  count_t             out_digit_count;
  logic               out_last_digit;

  digit_beat_t pending_digits[$];
  int          fault_count = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;

  binary_to_decimal_ascii_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_char  (out_digit_char),
    .out_digit_count (out_digit_count),
    .out_last_digit  (out_last_digit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int draw_wait(input bit idling);
    return idling ? int'($urandom_range(0, 7)) : 0;
  endfunction

  // Split a value into decimal digits, low first, then queue them high first.
  function automatic void expand_to_digits(input logic [VALUE_W-1:0] value);
    logic [DIGIT_W-1:0] low_first [DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 n;
    digit_beat_t        beat;
    rest = value;
    n    = 0;
    do begin
      low_first[n] = DIGIT_W'(rest % DECIMAL_BASE);
      rest         = rest / DECIMAL_BASE;
      n++;
    end while (rest != 0 && n < DIGITS);
    for (int k = 0; k < n; k++) begin
      beat.ch    = ASCII_ZERO + CHAR_W'(low_first[n - 1 - k]);
      beat.count = count_t'(n);
      beat.last  = (k == n - 1);
      pending_digits.push_back(beat);
    end
  endfunction

  function automatic void flag_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void check_digit(input digit_beat_t got);
    digit_beat_t want;
    if (pending_digits.size() == 0) begin
      flag_fault($sformatf("unexpected digit char=%0d count=%0d last=%0b",
                           got.ch, got.count, got.last));
      return;
    end
    want = pending_digits.pop_front();
    if (got.ch !== want.ch) begin
      flag_fault($sformatf("digit_char expected %0d got %0d", want.ch, got.ch));
    end
    if (got.count !== want.count) begin
      flag_fault($sformatf("digit_count expected %0d got %0d", want.count, got.count));
    end
    if (got.last !== want.last) begin
      flag_fault($sformatf("last_digit expected %0b got %0b", want.last, got.last));
    end
  endfunction

  // Result side: check each beat, then draw a fresh stall for the next one.
  always @(posedge clk) begin : result_side
    int hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      check_digit('{ch: out_digit_char, count: out_digit_count, last: out_last_digit});
      hold = draw_wait(out_idle_on);
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // Keep valid high across back-to-back beats; drop it only for a real gap.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    gap = draw_wait(in_idle_on);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expand_to_digits(value);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_with_digits(input int n);
    longint lo;
    longint hi;
    lo = 1;
    for (int k = 1; k < n; k++) lo = lo * DECIMAL_BASE;
    hi = lo * DECIMAL_BASE - 1;
    if (n == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return $urandom_range(int'(hi), int'(lo));
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom();
    end
    return random_with_digits($urandom_range(1, DIGITS));
  endfunction

  // Zero, every digit-count boundary, the full-scale value and alternating bits.
  task automatic test_corner_values();
    logic [VALUE_W-1:0] corner_values [24] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
      32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
      32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000, 32'd999999999,
      32'd1000000000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };
    foreach (corner_values[i]) send_value(corner_values[i]);
  endtask

  task automatic test_random_widths();
    repeat (200) send_value(random_value());
  endtask

  // Hold the input until every digit is out, then resume.
  task automatic test_drain_then_resume();
    repeat (20) send_value(random_value());
    drain_results();
    repeat (20) send_value(random_value());
  endtask

  task automatic test_back_to_back();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (60) send_value(random_value());
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Fast sender against a stalling receiver fills the stages.
  task automatic test_output_backpressure();
    in_idle_on = 1'b0;
    repeat (56) send_value(random_value());
    in_idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_values();
    test_random_widths();
    test_drain_then_resume();
    test_back_to_back();
    test_output_backpressure();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_digits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
